// File: src/mwtg_pkg.sv
package mwtg_pkg;

  localparam int unsigned FS_HZ       = 44100;
  localparam int unsigned PEAK_LEVEL  = 32760;
  localparam int unsigned TABLE_BITS  = 12;

  localparam int unsigned QSIZE      = 1 << (TABLE_BITS - 2);
  localparam int unsigned PHASE_W    = 16;
  localparam int unsigned FREQ_W     = 15;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned LFSR_W     = 32;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MAG_W      = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned NOISE_W    = 16;
  localparam int unsigned FREQ_WRAPS = ((1 << FREQ_W) - 1) / FS_HZ;

  localparam int unsigned RESET_TONE_FREQ   = 440;
  localparam int unsigned RESET_SECOND_FREQ = 450;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // index = (phase * RECIP_M) >> RECIP_SH gives floor(phase * 2^TABLE_BITS / FS_HZ)
  localparam int unsigned     RECIP_SH = 32;
  localparam longint unsigned RECIP_M  =
    ((64'd1 << (RECIP_SH + TABLE_BITS)) + FS_HZ - 1) / FS_HZ;
  localparam int unsigned     RECIP_W  = $clog2(RECIP_M + 1);
  localparam int unsigned     PROD_W   = PHASE_W + RECIP_W;

  typedef logic [PHASE_W-1:0]          phase_t;
  typedef logic [PHASE_W:0]            phase_sum_t;
  typedef logic [FREQ_W-1:0]           freq_t;
  typedef logic [MODE_W-1:0]           mode_t;
  typedef logic [LFSR_W-1:0]           lfsr_t;
  typedef logic [MAG_W-1:0]            mag_t;
  typedef logic [TABLE_BITS-1:0]       idx_t;
  typedef logic [TABLE_BITS-2:0]       addr_t;
  typedef logic [RECIP_W-1:0]          recip_t;
  typedef logic [PROD_W-1:0]           prod_t;
  typedef logic [NOISE_W-1:0]          noise_t;
  typedef logic signed [SAMPLE_W-1:0]  sample_t;
  typedef logic signed [SAMPLE_W:0]    wide_t;
  typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]       cfg_data_t;
  typedef logic [$clog2(PHASE_W)-1:0]  bit_cnt_t;

  localparam phase_t SR_PHASE         = phase_t'(FS_HZ);
  localparam phase_t SQ_PERIOD_RST    = phase_t'(FS_HZ / RESET_TONE_FREQ);
  localparam phase_t TONE_STEP_RST    = phase_t'(RESET_TONE_FREQ % FS_HZ);
  localparam phase_t SECOND_STEP_RST  = phase_t'(RESET_SECOND_FREQ % FS_HZ);
  localparam recip_t RECIP            = recip_t'(RECIP_M);
  localparam lfsr_t  LFSR_MASK        = 32'h8020_0003;
  localparam lfsr_t  LFSR_RST         = lfsr_t'(1);
  localparam noise_t NOISE_SCALE      = noise_t'(2 * PEAK_LEVEL + 1);
  localparam wide_t  PEAK_WIDE        = wide_t'(PEAK_LEVEL);
  localparam sample_t PEAK_POS        = sample_t'(PEAK_LEVEL);
  localparam sample_t PEAK_NEG        = -sample_t'(PEAK_LEVEL);

  localparam mode_t MODE_SINE   = 3'd0;
  localparam mode_t MODE_SQUARE = 3'd1;
  localparam mode_t MODE_WHITE  = 3'd2;
  localparam mode_t MODE_PINK   = 3'd3;
  localparam mode_t MODE_BEAT   = 3'd4;

  localparam cfg_idx_t REG_WAVE_MODE   = 2'd0;
  localparam cfg_idx_t REG_TONE_FREQ   = 2'd1;
  localparam cfg_idx_t REG_SECOND_FREQ = 2'd2;
  localparam cfg_idx_t REG_NOISE_SEED  = 2'd3;

  // quarter-wave entry k: Q30 Taylor series to x^11, truncating products
  function automatic mag_t sine_entry(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          v;
    x    = (longint'(k) * HALF_PI_Q30) / QSIZE;
    x2   = (x * x) >> 30;
    term = ((x * x2) >> 30) / 6;
    sum  = longint'(x) - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    if (sum < 0) sum = 0;
    v = (sum * longint'(PEAK_LEVEL) + (longint'(1) << 29)) >>> 30;
    if (v > longint'(PEAK_LEVEL)) v = longint'(PEAK_LEVEL);
    return mag_t'(v);
  endfunction

endpackage

// File: src/mwtg_if.sv
interface mwtg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface mwtg_out_if;
  logic              valid;
  logic              ready;
  mwtg_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// File: src/mwtg_period_div.sv
module mwtg_period_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  mwtg_pkg::freq_t  divisor_i,
  output logic             busy_o,
  output mwtg_pkg::phase_t period_o
);

  logic                       run_q;
  mwtg_pkg::bit_cnt_t         cnt_q;
  mwtg_pkg::freq_t            div_q;
  mwtg_pkg::freq_t            rem_q;
  mwtg_pkg::freq_t            rem_d;
  mwtg_pkg::phase_t           quot_q;
  logic [mwtg_pkg::FREQ_W:0]  trial;
  logic [mwtg_pkg::FREQ_W:0]  div_ext;
  logic                       ge;

  assign div_ext = {1'b0, div_q};
  assign trial   = {rem_q, mwtg_pkg::SR_PHASE[cnt_q]};
  assign ge      = trial >= div_ext;
  assign rem_d   = ge ? mwtg_pkg::freq_t'(trial - div_ext) : mwtg_pkg::freq_t'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      quot_q <= mwtg_pkg::SQ_PERIOD_RST;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= mwtg_pkg::bit_cnt_t'(mwtg_pkg::PHASE_W - 1);
    end else if (run_q) begin
      quot_q <= {quot_q[mwtg_pkg::PHASE_W-2:0], ge};
      cnt_q  <= cnt_q - mwtg_pkg::bit_cnt_t'(1);
      if (cnt_q == '0) run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= (divisor_i == '0) ? mwtg_pkg::freq_t'(1) : divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
    end
  end

  assign busy_o   = run_q;
  assign period_o = quot_q;

endmodule

// File: src/mwtg_sine_rom.sv
module mwtg_sine_rom (
  input  logic            clk_i,
  input  logic            en_i,
  input  mwtg_pkg::addr_t addr_a_i,
  input  mwtg_pkg::addr_t addr_b_i,
  output mwtg_pkg::mag_t  data_a_o,
  output mwtg_pkg::mag_t  data_b_o
);

  mwtg_pkg::mag_t tab [mwtg_pkg::QSIZE+1];
  mwtg_pkg::mag_t data_a_q;
  mwtg_pkg::mag_t data_b_q;

  for (genvar k = 0; k <= mwtg_pkg::QSIZE; k++) begin : g_entry
    assign tab[k] = mwtg_pkg::sine_entry(k);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_q <= tab[addr_a_i];
      data_b_q <= tab[addr_b_i];
    end
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

// File: src/multi_wave_tone_generator.sv
// channel   | dir | payload          | transfer when
// in_ch     | in  | restart  (1 bit) | in_ch.valid && in_ch.ready
// out_ch    | out | sample  (16 bit) | out_ch.valid && out_ch.ready
// cfg       | in  | idx 2, data 32   | cfg_we_i
//
// One sample per cycle when not stalled, through the input register, index
// multiply, quarter-wave table read and output register. Each stage holds only
// when the one after it is full and held, so a waiting result stops new input
// only once all four stages are full. A tone_freq write runs a serial divider
// for the square period; input is refused until it finishes. Reset loads the
// control and valid registers only, with their listed values; no clearing pass.
module multi_wave_tone_generator (
  input  logic                clk_i,
  input  logic                rst_ni,
  mwtg_in_if.sink             in_ch,
  mwtg_out_if.source          out_ch,
  input  logic                cfg_we_i,
  input  mwtg_pkg::cfg_idx_t  cfg_idx_i,
  input  mwtg_pkg::cfg_data_t cfg_data_i
);

  function automatic mwtg_pkg::phase_t freq_mod(mwtg_pkg::freq_t f);
    mwtg_pkg::phase_t v;
    v = mwtg_pkg::phase_t'(f);
    for (int i = 0; i < mwtg_pkg::FREQ_WRAPS; i++) begin
      if (v >= mwtg_pkg::SR_PHASE) v = v - mwtg_pkg::SR_PHASE;
    end
    return v;
  endfunction

  function automatic mwtg_pkg::phase_t phase_adv(mwtg_pkg::phase_t p, mwtg_pkg::phase_t s);
    mwtg_pkg::phase_sum_t sum;
    sum = {1'b0, p} + {1'b0, s};
    if (sum >= {1'b0, mwtg_pkg::SR_PHASE}) sum = sum - {1'b0, mwtg_pkg::SR_PHASE};
    return mwtg_pkg::phase_t'(sum);
  endfunction

  function automatic mwtg_pkg::idx_t table_idx(mwtg_pkg::phase_t p);
    mwtg_pkg::prod_t prod;
    prod = mwtg_pkg::prod_t'(p) * mwtg_pkg::prod_t'(mwtg_pkg::RECIP);
    return prod[mwtg_pkg::RECIP_SH +: mwtg_pkg::TABLE_BITS];
  endfunction

  function automatic mwtg_pkg::addr_t table_addr(mwtg_pkg::idx_t i);
    mwtg_pkg::addr_t off;
    off = {1'b0, i[mwtg_pkg::TABLE_BITS-3:0]};
    return i[mwtg_pkg::TABLE_BITS-2] ? mwtg_pkg::addr_t'(mwtg_pkg::QSIZE) - off : off;
  endfunction

  function automatic mwtg_pkg::wide_t halve(mwtg_pkg::wide_t v);
    return (v + mwtg_pkg::wide_t'({1'b0, v[mwtg_pkg::SAMPLE_W]})) >>> 1;
  endfunction

  function automatic mwtg_pkg::wide_t signed_mag(logic neg, mwtg_pkg::mag_t m);
    mwtg_pkg::wide_t w;
    w = mwtg_pkg::wide_t'({2'b00, m});
    return neg ? -w : w;
  endfunction

  // configuration and running state
  mwtg_pkg::mode_t  mode_q;
  mwtg_pkg::phase_t tone_step_q;
  mwtg_pkg::phase_t second_step_q;
  mwtg_pkg::lfsr_t  noise_q;
  mwtg_pkg::lfsr_t  noise_d;
  mwtg_pkg::phase_t tone_phase_q;
  mwtg_pkg::phase_t second_phase_q;
  mwtg_pkg::phase_t sq_pos_q;
  mwtg_pkg::phase_t sq_pos_d;
  mwtg_pkg::sample_t prev_q;

  logic             div_start;
  logic             div_busy;
  mwtg_pkg::phase_t sq_period;
  mwtg_pkg::phase_t sq_half;

  logic             in_ready;
  logic             in_fire;
  mwtg_pkg::phase_t ph_t;
  mwtg_pkg::phase_t ph_s;
  mwtg_pkg::phase_t pos;
  mwtg_pkg::phase_sum_t pos_inc;

  // pipeline
  logic              s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic              free1, free2, free3, free_out;
  logic              s1_rst_q, s2_rst_q, s3_rst_q;
  logic              s1_sq_q, s2_sq_q, s3_sq_q;
  mwtg_pkg::phase_t  s1_ph_t_q, s1_ph_s_q;
  mwtg_pkg::noise_t  s1_lo_q;
  mwtg_pkg::idx_t    s2_idx_t_q, s2_idx_s_q;
  mwtg_pkg::sample_t s2_noise_q, s3_noise_q;
  logic              s3_neg_t_q, s3_neg_s_q;
  mwtg_pkg::mag_t    mag_t, mag_s;
  mwtg_pkg::sample_t sample_q;
  mwtg_pkg::sample_t sample_d;

  logic [2*mwtg_pkg::NOISE_W-1:0] noise_prod;
  mwtg_pkg::wide_t   noise_w;
  mwtg_pkg::wide_t   sine_t, sine_s, prev_w, pink_w, beat_w;

  assign div_start = cfg_we_i && (cfg_idx_i == mwtg_pkg::REG_TONE_FREQ);

  mwtg_period_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (cfg_data_i[mwtg_pkg::FREQ_W-1:0]),
    .busy_o    (div_busy),
    .period_o  (sq_period)
  );

  assign sq_half = sq_period >> 1;

  assign free_out = !out_v_q || out_ch.ready;
  assign free3    = !s3_v_q || free_out;
  assign free2    = !s2_v_q || free3;
  assign free1    = !s1_v_q || free2;
  assign in_ready = free1 && !div_busy;
  assign in_fire  = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  assign ph_t    = in_ch.restart ? '0 : tone_phase_q;
  assign ph_s    = in_ch.restart ? '0 : second_phase_q;
  assign pos     = in_ch.restart ? '0 : sq_pos_q;
  assign pos_inc = {1'b0, pos} + mwtg_pkg::phase_sum_t'(1);
  assign sq_pos_d = (pos_inc >= {1'b0, sq_period}) ? '0 : mwtg_pkg::phase_t'(pos_inc);
  assign noise_d = noise_q[0] ? ((noise_q >> 1) ^ mwtg_pkg::LFSR_MASK) : (noise_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= mwtg_pkg::MODE_SINE;
      tone_step_q    <= mwtg_pkg::TONE_STEP_RST;
      second_step_q  <= mwtg_pkg::SECOND_STEP_RST;
      noise_q        <= mwtg_pkg::LFSR_RST;
      tone_phase_q   <= '0;
      second_phase_q <= '0;
      sq_pos_q       <= '0;
    end else begin
      if (in_fire) begin
        tone_phase_q   <= phase_adv(ph_t, tone_step_q);
        second_phase_q <= phase_adv(ph_s, second_step_q);
        sq_pos_q       <= sq_pos_d;
      end
      if (cfg_we_i && (cfg_idx_i == mwtg_pkg::REG_NOISE_SEED)) begin
        noise_q <= (cfg_data_i == '0) ? mwtg_pkg::LFSR_RST : cfg_data_i;
      end else if (in_fire) begin
        noise_q <= noise_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mwtg_pkg::REG_WAVE_MODE:   mode_q <= cfg_data_i[mwtg_pkg::MODE_W-1:0];
          mwtg_pkg::REG_TONE_FREQ:   tone_step_q <= freq_mod(cfg_data_i[mwtg_pkg::FREQ_W-1:0]);
          mwtg_pkg::REG_SECOND_FREQ:
            second_step_q <= freq_mod(cfg_data_i[mwtg_pkg::FREQ_W-1:0]);
          mwtg_pkg::REG_NOISE_SEED:  ;
          default: ;
        endcase
      end
    end
  end

  // valid bits and previous output sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      prev_q  <= '0;
    end else begin
      if (free1)    s1_v_q  <= in_fire;
      if (free2)    s2_v_q  <= s1_v_q;
      if (free3)    s3_v_q  <= s2_v_q;
      if (free_out) out_v_q <= s3_v_q;
      if (free_out && s3_v_q) prev_q <= sample_d;
    end
  end

  assign noise_prod = s1_lo_q * mwtg_pkg::NOISE_SCALE;
  assign noise_w    = mwtg_pkg::wide_t'({1'b0, noise_prod[2*mwtg_pkg::NOISE_W-1:mwtg_pkg::NOISE_W]})
                      - mwtg_pkg::PEAK_WIDE;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_rst_q  <= in_ch.restart;
      s1_ph_t_q <= ph_t;
      s1_ph_s_q <= ph_s;
      s1_sq_q   <= pos < sq_half;
      s1_lo_q   <= noise_q[mwtg_pkg::NOISE_W-1:0];
    end
    if (free2) begin
      s2_rst_q   <= s1_rst_q;
      s2_sq_q    <= s1_sq_q;
      s2_idx_t_q <= table_idx(s1_ph_t_q);
      s2_idx_s_q <= table_idx(s1_ph_s_q);
      s2_noise_q <= mwtg_pkg::sample_t'(noise_w);
    end
    if (free3) begin
      s3_rst_q   <= s2_rst_q;
      s3_sq_q    <= s2_sq_q;
      s3_noise_q <= s2_noise_q;
      s3_neg_t_q <= s2_idx_t_q[mwtg_pkg::TABLE_BITS-1];
      s3_neg_s_q <= s2_idx_s_q[mwtg_pkg::TABLE_BITS-1];
    end
    if (free_out) sample_q <= sample_d;
  end

  mwtg_sine_rom u_rom (
    .clk_i    (clk_i),
    .en_i     (free3),
    .addr_a_i (table_addr(s2_idx_t_q)),
    .addr_b_i (table_addr(s2_idx_s_q)),
    .data_a_o (mag_t),
    .data_b_o (mag_s)
  );

  assign sine_t = signed_mag(s3_neg_t_q, mag_t);
  assign sine_s = signed_mag(s3_neg_s_q, mag_s);
  assign prev_w = s3_rst_q ? '0 : mwtg_pkg::wide_t'(prev_q);
  assign pink_w = halve(mwtg_pkg::wide_t'(s3_noise_q)) + halve(prev_w);
  assign beat_w = halve(sine_t + sine_s);

  always_comb begin
    case (mode_q)
      mwtg_pkg::MODE_SINE:   sample_d = mwtg_pkg::sample_t'(sine_t);
      mwtg_pkg::MODE_SQUARE: sample_d = s3_sq_q ? mwtg_pkg::PEAK_POS : mwtg_pkg::PEAK_NEG;
      mwtg_pkg::MODE_WHITE:  sample_d = s3_noise_q;
      mwtg_pkg::MODE_PINK:   sample_d = mwtg_pkg::sample_t'(pink_w);
      mwtg_pkg::MODE_BEAT:   sample_d = mwtg_pkg::sample_t'(beat_w);
      default:               sample_d = '0;
    endcase
  end

  assign out_ch.valid  = out_v_q;
  assign out_ch.sample = sample_q;

`ifndef SYNTH
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tone_phase_q < mwtg_pkg::SR_PHASE && second_phase_q < mwtg_pkg::SR_PHASE)
    else $error("phase accumulator out of range");

  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    noise_q != '0)
    else $error("noise shift register stuck at zero");

  a_restart_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_ch.restart && !cfg_we_i |=> tone_phase_q == $past(tone_step_q))
    else $error("restart did not clear tone phase");

  a_stage_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q && free_out |=> out_v_q)
    else $error("sample lost between table stage and output");
`endif

endmodule

// File: test/multi_wave_tone_generator_tb.sv
module multi_wave_tone_generator_tb;
  import mwtg_pkg::*;

  localparam int PEAK = PEAK_LEVEL;
  localparam int RATE = FS_HZ;
  localparam mode_t MODE_SPARE_LO = 3'd5;
  localparam mode_t MODE_SPARE_HI = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 800;

  typedef struct {
    bit        is_cfg;
    cfg_idx_t  idx;
    cfg_data_t data;
    logic      restart;
    bit        lit;
    int        want;
  } row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i;
  cfg_idx_t  cfg_idx_i;
  cfg_data_t cfg_data_i;

  mwtg_in_if  in_ch ();
  mwtg_out_if out_ch ();

  multi_wave_tone_generator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  mode_t  mode_q    = MODE_SINE;
  freq_t  tone_f    = freq_t'(RESET_TONE_FREQ);
  freq_t  second_f  = freq_t'(RESET_SECOND_FREQ);
  phase_t tone_ph   = '0;
  phase_t second_ph = '0;
  phase_t sq_pos    = '0;
  phase_t sq_period = SQ_PERIOD_RST;
  phase_t sq_half   = SQ_PERIOD_RST / 2;
  lfsr_t  lfsr      = LFSR_RST;
  int     last_out  = 0;
  int     quarter [0:QSIZE];

  sample_t pending_samples [$];
  row_t    plan [$];
  int      mismatches   = 0;
  int      tx_gap_pct   = 0;
  int      rx_stall_pct = 0;
  int      hold_ticket  = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic flag(string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  function automatic sample_t tone_at(phase_t p);
    longint idx;
    int     off;
    idx = (longint'(p) << TABLE_BITS) / RATE;
    off = int'(idx) & (QSIZE - 1);
    case ((idx >> (TABLE_BITS - 2)) & 3)
      0:       return sample_t'(quarter[off]);
      1:       return sample_t'(quarter[QSIZE - off]);
      2:       return sample_t'(-quarter[off]);
      default: return sample_t'(-quarter[QSIZE - off]);
    endcase
  endfunction

  function automatic phase_t step_phase(phase_t p, freq_t f);
    int t;
    t = int'(p) + int'(f) % RATE;
    if (t >= RATE) t -= RATE;
    return phase_t'(t);
  endfunction

  function automatic void apply_reg(cfg_idx_t i, cfg_data_t d);
    int f;
    case (i)
      REG_WAVE_MODE:   mode_q = d[MODE_W-1:0];
      REG_TONE_FREQ: begin
        tone_f    = d[FREQ_W-1:0];
        f         = (tone_f == 0) ? 1 : int'(tone_f);
        sq_period = phase_t'(RATE / f);
        sq_half   = sq_period / 2;
      end
      REG_SECOND_FREQ: second_f = d[FREQ_W-1:0];
      default:         lfsr = (d == 0) ? LFSR_RST : lfsr_t'(d);
    endcase
  endfunction

  function automatic sample_t predict_sample(logic restart);
    int s;
    int noise;
    int a;
    int b;
    int nxt;
    if (restart) begin
      tone_ph   = '0;
      second_ph = '0;
      sq_pos    = '0;
      last_out  = 0;
    end
    noise = int'((longint'(lfsr[15:0]) * (2 * PEAK + 1)) >> 16) - PEAK;
    case (mode_q)
      MODE_SINE:   s = tone_at(tone_ph);
      MODE_SQUARE: s = (sq_pos < sq_half) ? PEAK : -PEAK;
      MODE_WHITE:  s = noise;
      MODE_PINK:   s = noise / 2 + last_out / 2;
      MODE_BEAT: begin
        a = tone_at(tone_ph);
        b = tone_at(second_ph);
        s = (a + b) / 2;
      end
      default:     s = 0;
    endcase
    tone_ph   = step_phase(tone_ph, tone_f);
    second_ph = step_phase(second_ph, second_f);
    nxt       = int'(sq_pos) + 1;
    sq_pos    = (nxt >= int'(sq_period)) ? '0 : phase_t'(nxt);
    lfsr      = lfsr[0] ? ((lfsr >> 1) ^ LFSR_MASK) : (lfsr >> 1);
    last_out  = s;
    return sample_t'(s);
  endfunction

  function automatic row_t cfg_row(cfg_idx_t i, cfg_data_t d);
    row_t r;
    r = '{1'b1, i, d, 1'b0, 1'b0, 0};
    return r;
  endfunction

  function automatic row_t item_row(logic restart, bit lit, int want);
    row_t r;
    r = '{1'b0, REG_WAVE_MODE, '0, restart, lit, want};
    return r;
  endfunction

  function automatic cfg_data_t pick_freq();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 1;
      2:       return 22050;
      3:       return (1 << FREQ_W) - 1;
      4:       return RATE / 4;
      default: return $urandom_range(22050, 1);
    endcase
  endfunction

  task automatic push(logic restart, bit lit, int want);
    sample_t got;
    while ($urandom_range(99) < tx_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    got = predict_sample(restart);
    pending_samples.push_back(lit ? sample_t'(want) : got);
  endtask

  // drop valid and let the pipeline empty before touching a register
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t i, cfg_data_t d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= i;
    cfg_data_i <= d;
    @(posedge clk_i);
    apply_reg(i, d);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int        hold_seen;
    int        hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    sample_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_samples.size() == 0) begin
        flag($sformatf("unexpected sample %0d", out_ch.sample));
      end else begin
        want = pending_samples.pop_front();
        if (out_ch.sample !== want)
          flag($sformatf("sample %0d, want %0d", out_ch.sample, want));
      end
    end
  end

  initial begin
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    row_t            r;
    cfg_data_t       seed;
    int              total;
    int              ph;
    int              n;

    in_ch.valid   <= 1'b0;
    in_ch.restart <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_WAVE_MODE;
    cfg_data_i    <= '0;

    // quarter-wave points, Q30 Taylor series up to x^11
    for (int k = 0; k <= QSIZE; k++) begin
      x    = (longint'(k) * HALF_PI_Q30) / QSIZE;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int j = 1; j <= 5; j++) begin
        term = ((term * x2) >> 30) / longint'((2 * j) * (2 * j + 1));
        if (j % 2 == 1) acc -= longint'(term);
        else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      acc = (acc * PEAK + (longint'(1) << 29)) >>> 30;
      quarter[k] = (acc > PEAK) ? PEAK : int'(acc);
    end

    plan.push_back(item_row(1'b0, 1'b1, 0));
    plan.push_back(item_row(1'b0, 1'b0, 0));
    plan.push_back(cfg_row(REG_TONE_FREQ, RATE / 4));
    plan.push_back(item_row(1'b1, 1'b1, 0));
    repeat (3) plan.push_back(item_row(1'b0, 1'b0, 0));
    plan.push_back(cfg_row(REG_TONE_FREQ, (1 << FREQ_W) - 1));
    repeat (2) plan.push_back(item_row(1'b0, 1'b0, 0));
    plan.push_back(cfg_row(REG_TONE_FREQ, 0));
    plan.push_back(item_row(1'b1, 1'b1, 0));
    plan.push_back(item_row(1'b0, 1'b1, 0));
    plan.push_back(cfg_row(REG_WAVE_MODE, MODE_SQUARE));
    plan.push_back(item_row(1'b1, 1'b1, PEAK));
    repeat (2) plan.push_back(item_row(1'b0, 1'b0, 0));
    plan.push_back(cfg_row(REG_TONE_FREQ, (1 << FREQ_W) - 1));
    plan.push_back(item_row(1'b0, 1'b1, -PEAK));
    plan.push_back(cfg_row(REG_WAVE_MODE, MODE_WHITE));
    plan.push_back(cfg_row(REG_NOISE_SEED, 0));
    plan.push_back(item_row(1'b0, 1'b1, -PEAK));
    plan.push_back(cfg_row(REG_NOISE_SEED, 32'hFFFF_FFFF));
    plan.push_back(item_row(1'b0, 1'b1, PEAK));
    plan.push_back(item_row(1'b0, 1'b0, 0));
    plan.push_back(cfg_row(REG_WAVE_MODE, MODE_PINK));
    plan.push_back(cfg_row(REG_NOISE_SEED, 32'h0000_FFFF));
    plan.push_back(item_row(1'b1, 1'b1, PEAK / 2));
    repeat (2) plan.push_back(item_row(1'b0, 1'b0, 0));
    plan.push_back(cfg_row(REG_WAVE_MODE, MODE_BEAT));
    plan.push_back(cfg_row(REG_TONE_FREQ, 1));
    plan.push_back(cfg_row(REG_SECOND_FREQ, (1 << FREQ_W) - 1));
    plan.push_back(item_row(1'b1, 1'b1, 0));
    repeat (2) plan.push_back(item_row(1'b0, 1'b0, 0));
    plan.push_back(cfg_row(REG_SECOND_FREQ, 0));
    plan.push_back(item_row(1'b0, 1'b0, 0));
    plan.push_back(cfg_row(REG_WAVE_MODE, MODE_SPARE_HI));
    plan.push_back(item_row(1'b0, 1'b1, 0));
    plan.push_back(cfg_row(REG_WAVE_MODE, MODE_SPARE_LO));
    plan.push_back(item_row(1'b0, 1'b1, 0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      r = plan[i];
      if (r.is_cfg) begin
        settle();
        write_reg(r.idx, r.data);
      end else begin
        push(r.restart, r.lit, r.want);
      end
    end

    total = 0;
    ph    = 0;
    while (total < RANDOM_ITEMS) begin
      settle();
      write_reg(REG_WAVE_MODE, ($urandom_range(5) == 0) ? $urandom_range(7) : ph % 5);
      if ($urandom_range(1)) write_reg(REG_TONE_FREQ, pick_freq());
      if ($urandom_range(1)) write_reg(REG_SECOND_FREQ, pick_freq());
      if ($urandom_range(1)) begin
        case ($urandom_range(5))
          0:       seed = '0;
          1:       seed = '1;
          default: seed = $urandom;
        endcase
        write_reg(REG_NOISE_SEED, seed);
      end
      case (ph % 4)
        0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_gap_pct = 67; rx_stall_pct = 0;  end
        2: begin tx_gap_pct = 0;  rx_stall_pct = 67; end
        default: begin tx_gap_pct = 6; rx_stall_pct = 6; end
      endcase
      n = $urandom_range(100, 50);
      repeat (n) push($urandom_range(19) == 0, 1'b0, 0);
      total += n;
      ph++;
    end

    // hold the receiver off long enough for the input to back up
    settle();
    write_reg(REG_WAVE_MODE, MODE_BEAT);
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_ticket++;
    repeat (60) push($urandom_range(19) == 0, 1'b0, 0);

    in_ch.valid <= 1'b0;
    n = 0;
    while (pending_samples.size() != 0 && n < 100000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_samples.size() != 0)
      flag($sformatf("%0d samples never arrived", pending_samples.size()));
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
src/mwtg_pkg.sv
src/mwtg_if.sv
src/mwtg_period_div.sv
src/mwtg_sine_rom.sv
src/multi_wave_tone_generator.sv
test/multi_wave_tone_generator_tb.sv
